[hdl/pbr_pkg.sv]
`timescale 1ns / 1ps

package pbr_pkg;

    // Number of entries the store holds.
    localparam int STORE_DEPTH = 64;
    // Index width of the store and width of a count that can hold the depth itself.
    localparam int IDX_W = $clog2(STORE_DEPTH);
    localparam int CNT_W = $clog2(STORE_DEPTH + 1);

    // Priority value whose pass also collects the changes-often entries.
    localparam logic [7:0] OFTEN_PASS = 8'd64;

    typedef struct packed {
        logic [15:0] tag;
        logic [7:0]  prio;
        logic        often;
    } entry_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        entry_t           data;
    } ram_wr_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
    } ram_rd_t;

endpackage

[hdl/pbr_entry_ram.sv]
`timescale 1ns / 1ps

module pbr_entry_ram
    import pbr_pkg::*;
(
    input  logic    clk,
    input  ram_wr_t wr,
    input  ram_rd_t rd,
    output entry_t  rd_data
);

    // One write port and one read port; the read data is registered and holds
    // its value until the next enabled read.
    entry_t mem [STORE_DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd.en)
        begin
            rd_data_reg <= mem[rd.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hdl/priority_bucket_reorder.sv]
`timescale 1ns / 1ps
// Loading writes each accepted request that fits into the store; the store write port takes one entry each cycle.
// Ordering runs for 65 to 256 passes; each pass scans from the front and swaps every match to the front,
// all through the single read and single write port of the store.
// Emission reads each entry from the store, then loads it into the output register.
// Reset (rst_n, asynchronous, active low) clears the counters, flags and state machine;
// the store contents stay undefined and are never read before they are written.

module priority_bucket_reorder
    import pbr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic [15:0] item_tag,
    input  logic [7:0]  item_priority,
    input  logic        item_often,
    input  logic        item_last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] out_tag,
    output logic [7:0]  out_priority,
    output logic        out_often,
    output logic        out_last,
    output logic        out_overflow
);

    // The sequencer walks the store one entry at a time. A scan step reads the
    // entry at the scan position; a match that is not already at the front
    // reads the front entry and then writes the two back in swapped order, one
    // write per cycle. Every read is issued only after the preceding write has
    // landed, so no forwarding is needed.
    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SCAN,
        ST_EVAL,
        ST_FRONT,
        ST_SWAP,
        ST_EMIT_RD,
        ST_EMIT
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             dropped_reg, dropped_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic [CNT_W-1:0] front_reg, front_next;
    logic [7:0]       pass_reg, pass_next;
    logic             pending_reg, pending_next;
    entry_t           hold_k_reg, hold_k_next;
    entry_t           hold_f_reg, hold_f_next;

    logic             out_valid_reg, out_valid_next;
    entry_t           out_entry_reg, out_entry_next;
    logic             out_last_reg, out_last_next;
    logic             out_overflow_reg, out_overflow_next;

    ram_wr_t          ram_wr;
    ram_rd_t          ram_rd;
    entry_t           ram_data;

    logic             item_accept;
    logic             match;
    logic             out_free;

    pbr_entry_ram u_ram (
        .clk     (clk),
        .wr      (ram_wr),
        .rd      (ram_rd),
        .rd_data (ram_data)
    );

    // Requests are taken only while loading; the output register parts the
    // two sides, so a new list may load while results still wait.
    assign item_stall  = (state_reg != ST_LOAD);
    assign item_accept = item_valid && !item_stall;
    assign out_free    = !out_valid_reg || !out_stall;

    // An entry joins the current pass on an exact priority match, and the
    // pass at the changes-often value also takes every flagged entry.
    assign match = (ram_data.prio == pass_reg) || ((pass_reg == OFTEN_PASS) && ram_data.often);

    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        dropped_next      = dropped_reg;
        k_next            = k_reg;
        front_next        = front_reg;
        pass_next         = pass_reg;
        pending_next      = pending_reg;
        hold_k_next       = hold_k_reg;
        hold_f_next       = hold_f_reg;
        out_valid_next    = out_valid_reg && out_stall;
        out_entry_next    = out_entry_reg;
        out_last_next     = out_last_reg;
        out_overflow_next = out_overflow_reg;
        ram_wr            = '0;
        ram_rd            = '0;

        case (state_reg)
            ST_LOAD:
            begin
                if (item_accept)
                begin
                    if (count_reg < CNT_W'(STORE_DEPTH))
                    begin
                        ram_wr.en        = 1'b1;
                        ram_wr.addr      = count_reg[IDX_W-1:0];
                        ram_wr.data.tag  = item_tag;
                        ram_wr.data.prio = item_priority;
                        ram_wr.data.often = item_often;
                        count_next       = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        dropped_next = 1'b1;
                    end
                    // A last request always leaves at least one stored entry,
                    // since an empty store accepts it.
                    if (item_last)
                    begin
                        state_next   = ST_SCAN;
                        k_next       = '0;
                        front_next   = '0;
                        pass_next    = '0;
                        pending_next = 1'b0;
                    end
                end
            end

            ST_SCAN:
            begin
                if (k_reg < count_reg)
                begin
                    ram_rd.en   = 1'b1;
                    ram_rd.addr = k_reg[IDX_W-1:0];
                    state_next  = ST_EVAL;
                end
                else if ((pass_reg < OFTEN_PASS) || pending_reg)
                begin
                    // Another pass starts from the current front.
                    pass_next    = pass_reg + 8'd1;
                    k_next       = front_reg;
                    pending_next = 1'b0;
                end
                else
                begin
                    k_next     = '0;
                    state_next = ST_EMIT_RD;
                end
            end

            ST_EVAL:
            begin
                if (match)
                begin
                    if (front_reg == k_reg)
                    begin
                        front_next = front_reg + CNT_W'(1);
                        k_next     = k_reg + CNT_W'(1);
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        hold_k_next = ram_data;
                        ram_rd.en   = 1'b1;
                        ram_rd.addr = front_reg[IDX_W-1:0];
                        state_next  = ST_FRONT;
                    end
                end
                else
                begin
                    if (ram_data.prio > pass_reg)
                    begin
                        pending_next = 1'b1;
                    end
                    k_next     = k_reg + CNT_W'(1);
                    state_next = ST_SCAN;
                end
            end

            ST_FRONT:
            begin
                ram_wr.en   = 1'b1;
                ram_wr.addr = front_reg[IDX_W-1:0];
                ram_wr.data = hold_k_reg;
                hold_f_next = ram_data;
                state_next  = ST_SWAP;
            end

            ST_SWAP:
            begin
                ram_wr.en   = 1'b1;
                ram_wr.addr = k_reg[IDX_W-1:0];
                ram_wr.data = hold_f_reg;
                front_next  = front_reg + CNT_W'(1);
                k_next      = k_reg + CNT_W'(1);
                state_next  = ST_SCAN;
            end

            ST_EMIT_RD:
            begin
                ram_rd.en   = 1'b1;
                ram_rd.addr = k_reg[IDX_W-1:0];
                state_next  = ST_EMIT;
            end

            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next    = 1'b1;
                    out_entry_next    = ram_data;
                    out_last_next     = (k_reg + CNT_W'(1) == count_reg);
                    out_overflow_next = dropped_reg;
                    if (k_reg + CNT_W'(1) == count_reg)
                    begin
                        // The list is out; the block empties itself.
                        count_next   = '0;
                        dropped_next = 1'b0;
                        state_next   = ST_LOAD;
                    end
                    else
                    begin
                        k_next     = k_reg + CNT_W'(1);
                        state_next = ST_EMIT_RD;
                    end
                end
            end

            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            dropped_reg   <= 1'b0;
            k_reg         <= '0;
            front_reg     <= '0;
            pass_reg      <= '0;
            pending_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            dropped_reg   <= dropped_next;
            k_reg         <= k_next;
            front_reg     <= front_next;
            pass_reg      <= pass_next;
            pending_reg   <= pending_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        hold_k_reg       <= hold_k_next;
        hold_f_reg       <= hold_f_next;
        out_entry_reg    <= out_entry_next;
        out_last_reg     <= out_last_next;
        out_overflow_reg <= out_overflow_next;
    end

    assign out_valid    = out_valid_reg;
    assign out_tag      = out_entry_reg.tag;
    assign out_priority = out_entry_reg.prio;
    assign out_often    = out_entry_reg.often;
    assign out_last     = out_last_reg;
    assign out_overflow = out_overflow_reg;

    // The fill count never passes the store depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(STORE_DEPTH))
        else $error("entry count exceeds store depth");

    // During ordering the front never runs ahead of the scan position.
    a_front_le_k: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN || state_reg == ST_EVAL || state_reg == ST_FRONT
            || state_reg == ST_SWAP) |-> (front_reg <= k_reg))
        else $error("front passed scan position");

    // A request that finds the store full marks the list as overflowed.
    a_drop_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (item_accept && count_reg == CNT_W'(STORE_DEPTH)) |=> dropped_reg)
        else $error("dropped request not flagged");

    // Loading the final result of a list empties the block.
    a_emit_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && out_free && (k_reg + CNT_W'(1) == count_reg))
            |=> (count_reg == '0 && !dropped_reg && out_valid_reg && out_last_reg))
        else $error("block not emptied after last result");

endmodule
